>>> rtl/core/mtd_pkg.sv
// Shared types, constants and command codes for the multicore task dispatcher.
package mtd_pkg;

    localparam int MAX_TASKS_DEF = 32;
    localparam int MAX_CPUS_DEF  = 4;
    localparam int RESULT_CAP    = 4;

    localparam logic [1:0]  CMD_WRITE = 2'd0;
    localparam logic [1:0]  CMD_TICK  = 2'd1;
    localparam logic [1:0]  CMD_READ  = 2'd2;

    localparam logic [1:0]  ST_READY   = 2'd1;
    localparam logic [1:0]  ST_RUNNING = 2'd2;
    localparam logic [2:0]  CPU_NONE   = 3'd4;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_TASKS   = 2'd1;
    localparam logic [1:0] REG_CPUS    = 2'd2;
    localparam logic [1:0] REG_QUANTUM = 2'd3;

    // Entry word layout: state, remaining, priority, arrival, duration, slice, cpu
    localparam int ENTRY_W = 2 + 16 + 8 + 16 + 16 + 16 + 3;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  task_index;
        logic [1:0]  task_state;
        logic [15:0] remain_ticks;
        logic [7:0]  priority_level;
        logic [15:0] arrive_tick;
        logic [15:0] total_duration;
        logic [15:0] slice_ticks;
        logic [2:0]  running_cpu;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cpu_index;
        logic [4:0]  chosen_task;
        logic        assigned;
        logic        switched;
        logic        lottery;
        logic [1:0]  read_state;
        logic [2:0]  read_cpu;
        logic [15:0] read_slice;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]  state;
        logic [15:0] remaining;
        logic [7:0]  priority_lvl;
        logic [15:0] arrival;
        logic [15:0] duration;
        logic [15:0] slice;
        logic [2:0]  cpu;
    } entry_t;

    // Datapath operation selected by the controller for the current cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,      // write input command fields into the table
        OP_RD_ENTRY,   // issue read of the commanded entry
        OP_RD_ISSUE,   // issue read of the walk index
        OP_RELEASE,    // quantum release check on read data
        OP_PREV_ISSUE, // issue read of the CPU's previous task
        OP_PREV_CHECK, // latch current-task candidate
        OP_DEMOTE,     // free running tasks of this CPU
        OP_SELECT,     // compare read data with best
        OP_COMMIT,     // write chosen task, update CPU tables
        OP_RESULT,     // emit tick result
        OP_READ_OUT    // emit read result
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] idx;   // walk index
        logic [3:0] cpu;   // CPU under work
        logic       first; // clear best at start of select walk
        logic       last;  // last result of the command
    } ctl_t;

    typedef struct packed {
        logic [8:0] count;
        logic [4:0] ncpu;
    } stat_t;

endpackage

>>> rtl/core/mtd_ram.sv
// Generic simple dual-port RAM with registered read.
module mtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/mtd_datapath.sv
// Task table, CPU tables, LFSR and result register of the dispatcher.
module mtd_datapath #(
    parameter int MAX_TASKS = mtd_pkg::MAX_TASKS_DEF,
    parameter int MAX_CPUS  = mtd_pkg::MAX_CPUS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mtd_pkg::ctl_t   ctl,
    input  mtd_pkg::cmd_t   cmd_in,
    input  logic            cmd_load,
    input  logic            mode,
    input  logic [5:0]      tasks_cfg,
    input  logic [2:0]      cpus_cfg,
    input  logic [15:0]     quantum,
    output mtd_pkg::stat_t  stat,
    output mtd_pkg::result_t result,
    output logic            result_valid
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

    mtd_pkg::cmd_t    cmd_reg;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    mtd_pkg::entry_t  wdata;
    mtd_pkg::entry_t  rdata;

    logic [8:0]       cur_task_reg [MAX_CPUS];
    logic [8:0]       cur_task_next;
    logic [15:0]      lfsr_reg;
    logic [15:0]      lfsr_next;
    logic [8:0]       cand_reg;
    logic [8:0]       prev_reg;
    logic             prev_ok;
    logic [8:0]       best_reg;
    logic [8:0]       best_next;
    mtd_pkg::entry_t  best_e_reg;
    mtd_pkg::entry_t  best_e_next;
    logic             best_v_reg;
    logic             best_v_next;
    logic             drawn_reg;
    logic             drawn_next;
    logic [7:0]       walk_reg;
    mtd_pkg::result_t result_reg;
    mtd_pkg::result_t result_next;
    logic             result_v_reg;
    logic [CW-1:0]    cpu_sel;
    logic             take;
    logic             prim_lt;
    logic             prim_eq;

    assign cpu_sel = ctl.cpu[CW-1:0];

    always_comb
    begin
        stat.count = (tasks_cfg > 6'(MAX_TASKS > 63 ? 63 : MAX_TASKS))
                     ? 9'(MAX_TASKS > 63 ? 63 : MAX_TASKS) : 9'(tasks_cfg);
        if (MAX_TASKS > 63)
        begin
            stat.count = 9'(tasks_cfg);
        end
        stat.ncpu = 5'(cpus_cfg);
        if (stat.ncpu > 5'(MAX_CPUS))
        begin
            stat.ncpu = 5'(MAX_CPUS);
        end
        if (stat.ncpu > 5'(mtd_pkg::RESULT_CAP))
        begin
            stat.ncpu = 5'(mtd_pkg::RESULT_CAP);
        end
    end

    mtd_ram #(.WIDTH(mtd_pkg::ENTRY_W), .DEPTH(MAX_TASKS)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Comparison of the walked entry (rdata at walk_reg) against best.
    always_comb
    begin
        if (mode)
        begin
            prim_lt = rdata.priority_lvl > best_e_reg.priority_lvl;
            prim_eq = rdata.priority_lvl == best_e_reg.priority_lvl;
        end
        else
        begin
            prim_lt = rdata.remaining < best_e_reg.remaining;
            prim_eq = rdata.remaining == best_e_reg.remaining;
        end
    end

    // Walk: read of ctl.idx is issued while entry walk_reg is processed and written.
    always_comb
    begin
        we          = 1'b0;
        waddr       = walk_reg[AW-1:0];
        raddr       = ctl.idx[AW-1:0];
        wdata       = rdata;
        best_next   = best_reg;
        best_e_next = best_e_reg;
        best_v_next = best_v_reg;
        drawn_next  = drawn_reg;
        lfsr_next   = lfsr_reg;
        take        = 1'b0;
        cur_task_next = cur_task_reg[cpu_sel];
        case (ctl.op)
            mtd_pkg::OP_WRITE:
            begin
                waddr = AW'(cmd_reg.task_index);
                we = (9'(cmd_reg.task_index) < 9'(MAX_TASKS));
                wdata.state = cmd_reg.task_state;
                wdata.remaining = cmd_reg.remain_ticks;
                wdata.priority_lvl = cmd_reg.priority_level;
                wdata.arrival = cmd_reg.arrive_tick;
                wdata.duration = cmd_reg.total_duration;
                wdata.slice = cmd_reg.slice_ticks;
                wdata.cpu = cmd_reg.running_cpu;
            end
            mtd_pkg::OP_RD_ENTRY:
            begin
                raddr = AW'(cmd_reg.task_index);
            end
            mtd_pkg::OP_PREV_ISSUE:
            begin
                raddr = cur_task_reg[cpu_sel][AW-1:0];
            end
            mtd_pkg::OP_RD_ISSUE:
            begin
                if (ctl.first)
                begin
                    best_v_next = 1'b0;
                    drawn_next  = 1'b0;
                end
            end
            mtd_pkg::OP_RELEASE:
            begin
                if (rdata.state == mtd_pkg::ST_RUNNING && rdata.slice >= quantum)
                begin
                    we = 1'b1;
                    wdata.state = mtd_pkg::ST_READY;
                    wdata.cpu = mtd_pkg::CPU_NONE;
                    wdata.slice = '0;
                end
            end
            mtd_pkg::OP_DEMOTE:
            begin
                if (rdata.state == mtd_pkg::ST_RUNNING && rdata.cpu == 3'(ctl.cpu))
                begin
                    we = 1'b1;
                    wdata.state = mtd_pkg::ST_READY;
                end
            end
            mtd_pkg::OP_SELECT:
            begin
                if (rdata.state == mtd_pkg::ST_READY)
                begin
                    if (!best_v_reg || prim_lt)
                    begin
                        take = 1'b1;
                    end
                    else if (prim_eq)
                    begin
                        if (best_reg == cand_reg)
                        begin
                            take = 1'b0;
                        end
                        else if (9'(walk_reg) == cand_reg)
                        begin
                            take = 1'b1;
                        end
                        else if (best_e_reg.arrival != rdata.arrival)
                        begin
                            take = rdata.arrival < best_e_reg.arrival;
                        end
                        else if (best_e_reg.duration != rdata.duration)
                        begin
                            take = rdata.duration < best_e_reg.duration;
                        end
                        else
                        begin
                            drawn_next = 1'b1;
                            take = lfsr_reg[0];
                            lfsr_next = lfsr_reg >> 1;
                            if (lfsr_reg[0])
                            begin
                                lfsr_next = lfsr_next ^ mtd_pkg::LFSR_MASK;
                            end
                        end
                    end
                    if (take)
                    begin
                        best_next   = 9'(walk_reg);
                        best_e_next = rdata;
                        best_v_next = 1'b1;
                    end
                end
            end
            mtd_pkg::OP_COMMIT:
            begin
                waddr = best_reg[AW-1:0];
                if (best_v_reg)
                begin
                    we = 1'b1;
                    wdata = best_e_reg;
                    wdata.state = mtd_pkg::ST_RUNNING;
                    wdata.cpu = 3'(ctl.cpu);
                    if (prev_reg != best_reg)
                    begin
                        wdata.slice = '0;
                    end
                    cur_task_next = best_reg;
                end
                else
                begin
                    cur_task_next = '1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Current-task candidate check uses the registered read of prev.
    assign prev_ok = (prev_reg < stat.count) &&
                     (rdata.state == mtd_pkg::ST_READY || rdata.state == mtd_pkg::ST_RUNNING);

    always_comb
    begin
        result_next = '0;
        if (ctl.op == mtd_pkg::OP_RESULT)
        begin
            result_next.cpu_index   = 2'(ctl.cpu);
            result_next.lottery     = drawn_reg;
            result_next.assigned    = best_v_reg;
            result_next.chosen_task = best_v_reg ? 5'(best_reg) : 5'd0;
            result_next.switched    = best_v_reg && (prev_reg != best_reg);
            result_next.last        = ctl.last;
        end
        else if (ctl.op == mtd_pkg::OP_READ_OUT)
        begin
            if (9'(cmd_reg.task_index) < 9'(MAX_TASKS))
            begin
                result_next.read_state = rdata.state;
                result_next.read_cpu   = rdata.cpu;
                result_next.read_slice = rdata.slice;
            end
            result_next.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CPUS; c++)
            begin
                cur_task_reg[c] <= '1;
            end
            lfsr_reg     <= mtd_pkg::LFSR_SEED;
            result_v_reg <= 1'b0;
            best_v_reg   <= 1'b0;
            drawn_reg    <= 1'b0;
        end
        else
        begin
            lfsr_reg   <= lfsr_next;
            best_v_reg <= best_v_next;
            drawn_reg  <= drawn_next;
            if (ctl.op == mtd_pkg::OP_COMMIT)
            begin
                cur_task_reg[cpu_sel] <= cur_task_next;
            end
            result_v_reg <= (ctl.op == mtd_pkg::OP_RESULT) ||
                            (ctl.op == mtd_pkg::OP_READ_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_load)
        begin
            cmd_reg <= cmd_in;
        end
        walk_reg   <= ctl.idx;
        best_reg   <= best_next;
        best_e_reg <= best_e_next;
        if (ctl.op == mtd_pkg::OP_PREV_ISSUE)
        begin
            prev_reg <= cur_task_reg[cpu_sel];
        end
        if (ctl.op == mtd_pkg::OP_PREV_CHECK)
        begin
            cand_reg <= prev_ok ? prev_reg : 9'h1FF;
        end
        result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = result_v_reg;

endmodule

>>> rtl/core/mtd_ctrl.sv
// Sequencer of the dispatcher: walks the table for release, demote and select.
module mtd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     command,
    input  mtd_pkg::stat_t stat,
    output logic           busy,
    output logic           cmd_load,
    output mtd_pkg::ctl_t  ctl
);

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_READ_ISSUE, S_READ_OUT, S_REL, S_PREV, S_PREV_CHK,
        S_DEM, S_SEL, S_COMMIT, S_RESULT, S_DRAIN
    } state_t;

    state_t      state_reg;
    logic [8:0]  idx_reg;
    logic [3:0]  cpu_reg;

    // A walk issues idx_reg and processes idx-1 the next cycle; idx_reg==count
    // is the drain of the last read.
    always_comb
    begin
        ctl = '0;
        ctl.idx = 8'(idx_reg);
        ctl.cpu = cpu_reg;
        ctl.last = (5'(cpu_reg) + 5'd1 == stat.ncpu);
        case (state_reg)
            S_WRITE:      ctl.op = mtd_pkg::OP_WRITE;
            S_READ_ISSUE:
            begin
                ctl.op = mtd_pkg::OP_RD_ENTRY;
            end
            S_READ_OUT:   ctl.op = mtd_pkg::OP_READ_OUT;
            S_REL:        ctl.op = (idx_reg == 9'd0) ? mtd_pkg::OP_RD_ISSUE
                                                     : mtd_pkg::OP_RELEASE;
            S_PREV:       ctl.op = mtd_pkg::OP_PREV_ISSUE;
            S_PREV_CHK:   ctl.op = mtd_pkg::OP_PREV_CHECK;
            S_DEM:        ctl.op = (idx_reg == 9'd0) ? mtd_pkg::OP_RD_ISSUE
                                                     : mtd_pkg::OP_DEMOTE;
            S_SEL:
            begin
                ctl.op = (idx_reg == 9'd0) ? mtd_pkg::OP_RD_ISSUE : mtd_pkg::OP_SELECT;
                ctl.first = (idx_reg == 9'd0);
            end
            S_COMMIT:     ctl.op = mtd_pkg::OP_COMMIT;
            S_RESULT:     ctl.op = mtd_pkg::OP_RESULT;
            default:      ctl.op = mtd_pkg::OP_NONE;
        endcase
    end

    assign busy     = (state_reg != S_IDLE);
    assign cmd_load = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cpu_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    cpu_reg <= '0;
                    if (start)
                    begin
                        case (command)
                            mtd_pkg::CMD_WRITE: state_reg <= S_WRITE;
                            mtd_pkg::CMD_READ:  state_reg <= S_READ_ISSUE;
                            mtd_pkg::CMD_TICK:
                            begin
                                if (stat.ncpu != 5'd0)
                                begin
                                    state_reg <= (stat.count == 9'd0) ? S_PREV : S_REL;
                                end
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_WRITE:      state_reg <= S_IDLE;
                S_READ_ISSUE: state_reg <= S_READ_OUT;
                S_READ_OUT:   state_reg <= S_IDLE;
                S_REL, S_DEM, S_SEL:
                begin
                    if (idx_reg == stat.count)
                    begin
                        idx_reg <= '0;
                        state_reg <= (state_reg == S_REL) ? S_PREV :
                                     (state_reg == S_DEM) ? S_SEL : S_COMMIT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 9'd1;
                    end
                end
                S_PREV:     state_reg <= S_PREV_CHK;
                S_PREV_CHK:
                begin
                    idx_reg   <= '0;
                    state_reg <= (stat.count == 9'd0) ? S_SEL : S_DEM;
                end
                S_COMMIT:   state_reg <= S_RESULT;
                S_RESULT:
                begin
                    if (5'(cpu_reg) + 5'd1 == stat.ncpu)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        cpu_reg   <= cpu_reg + 4'd1;
                        state_reg <= S_PREV;
                    end
                end
                S_DRAIN:    state_reg <= S_IDLE;
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/core/multicore_task_dispatcher.sv
// Multicore task dispatcher top level: APB registers, controller and datapath.
// Write: busy 1 cycle. Read: busy 2 cycles, result strobe in the cycle after.
// Tick with T > 0 tasks in use: busy T+2 + ncpu*(2*(T+1)+4) cycles, one table entry
// per cycle walked once for release and twice per CPU; one result per CPU.
// One command at a time; results are one-cycle strobes and cannot be stalled.
// Reset clears registers to their defaults, CPU tables to none, LFSR to seed.
module multicore_task_dispatcher #(
    parameter int MAX_TASKS = mtd_pkg::MAX_TASKS_DEF,
    parameter int MAX_CPUS  = mtd_pkg::MAX_CPUS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mtd_pkg::cmd_t    cmd,
    output logic             result_strobe,
    output mtd_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic            mode_reg;
    logic [5:0]      tasks_reg;
    logic [2:0]      cpus_reg;
    logic [15:0]     quantum_reg;
    logic            cmd_load;
    mtd_pkg::ctl_t   ctl;
    mtd_pkg::stat_t  stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            tasks_reg   <= '0;
            cpus_reg    <= 3'd1;
            quantum_reg <= 16'd4;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                mtd_pkg::REG_MODE:    mode_reg    <= pwdata[0];
                mtd_pkg::REG_TASKS:   tasks_reg   <= pwdata[5:0];
                mtd_pkg::REG_CPUS:    cpus_reg    <= pwdata[2:0];
                mtd_pkg::REG_QUANTUM: quantum_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            mtd_pkg::REG_MODE:    prdata = {31'd0, mode_reg};
            mtd_pkg::REG_TASKS:   prdata = {26'd0, tasks_reg};
            mtd_pkg::REG_CPUS:    prdata = {29'd0, cpus_reg};
            mtd_pkg::REG_QUANTUM: prdata = {16'd0, quantum_reg};
            default:              prdata = '0;
        endcase
    end

    mtd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .command  (cmd.command),
        .stat     (stat),
        .busy     (busy),
        .cmd_load (cmd_load),
        .ctl      (ctl)
    );

    mtd_datapath #(.MAX_TASKS(MAX_TASKS), .MAX_CPUS(MAX_CPUS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cmd_in       (cmd),
        .cmd_load     (cmd_load),
        .mode         (mode_reg),
        .tasks_cfg    (tasks_reg),
        .cpus_cfg     (cpus_reg),
        .quantum      (quantum_reg),
        .stat         (stat),
        .result       (result),
        .result_valid (result_strobe)
    );

endmodule

>>> tb/multicore_task_dispatcher_tb.sv
// Self-checking testbench for the task dispatcher: table writes, reads and ticks.
module multicore_task_dispatcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTASK      = 32;
    localparam int NCPU       = 4;
    localparam int CYCLE_LIMIT = 1500000;
    localparam logic [1:0] CMD_NOP = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             start = 1'b0;
    logic             busy;
    mtd_pkg::cmd_t    cmd = '0;
    logic             result_strobe;
    mtd_pkg::result_t result;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [3:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    multicore_task_dispatcher DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .result_strobe(result_strobe), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // scheduler mirror
    logic        mode_prio;
    logic [5:0]  task_limit;
    logic [2:0]  cpu_limit;
    logic [15:0] quantum;
    logic [1:0]  tbl_state    [NTASK];
    logic [15:0] tbl_remain   [NTASK];
    logic [7:0]  tbl_prio     [NTASK];
    logic [15:0] tbl_arrival  [NTASK];
    logic [15:0] tbl_duration [NTASK];
    logic [15:0] tbl_slice    [NTASK];
    logic [2:0]  tbl_cpu      [NTASK];
    int          cpu_task     [NCPU];
    logic [15:0] coin_reg;

    mtd_pkg::cmd_t    pending_cmds[$];
    mtd_pkg::result_t expected_results[$];
    int          gap_left;
    bit          idle_en;
    int          cycles;
    int          mismatches;
    int          ticks_sent;
    int          reads_sent;
    int          coin_results;
    int          results_seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit coin_flip();
        bit b;
        b = coin_reg[0];
        coin_reg = coin_reg >> 1;
        if (b)
            coin_reg = coin_reg ^ mtd_pkg::LFSR_MASK;
        return b;
    endfunction

    function automatic int settle_tie(int a, int b, int cur, ref bit drawn);
        if (a == cur) return a;
        if (b == cur) return b;
        if (tbl_arrival[a] != tbl_arrival[b])
            return (tbl_arrival[a] < tbl_arrival[b]) ? a : b;
        if (tbl_duration[a] != tbl_duration[b])
            return (tbl_duration[a] < tbl_duration[b]) ? a : b;
        drawn = 1'b1;
        return coin_flip() ? b : a;
    endfunction

    function automatic int best_ready(int count, int cur, ref bit drawn);
        int best;
        best = -1;
        for (int i = 0; i < count; i++)
        begin
            if (tbl_state[i] != mtd_pkg::ST_READY) continue;
            if (best < 0)
            begin
                best = i;
                continue;
            end
            if (mode_prio)
            begin
                if (tbl_prio[i] > tbl_prio[best]) best = i;
                else if (tbl_prio[i] == tbl_prio[best]) best = settle_tie(best, i, cur, drawn);
            end
            else
            begin
                if (tbl_remain[i] < tbl_remain[best]) best = i;
                else if (tbl_remain[i] == tbl_remain[best])
                    best = settle_tie(best, i, cur, drawn);
            end
        end
        return best;
    endfunction

    task automatic predict_dispatch(input mtd_pkg::cmd_t c);
        int      count;
        int      ncpu;
        int      cur;
        int      prev;
        int      chosen;
        bit      drawn;
        mtd_pkg::result_t r;
        case (c.command)
            mtd_pkg::CMD_WRITE:
            begin
                tbl_state[c.task_index]    = c.task_state;
                tbl_remain[c.task_index]   = c.remain_ticks;
                tbl_prio[c.task_index]     = c.priority_level;
                tbl_arrival[c.task_index]  = c.arrive_tick;
                tbl_duration[c.task_index] = c.total_duration;
                tbl_slice[c.task_index]    = c.slice_ticks;
                tbl_cpu[c.task_index]      = c.running_cpu;
            end
            mtd_pkg::CMD_READ:
            begin
                r            = '0;
                r.read_state = tbl_state[c.task_index];
                r.read_cpu   = tbl_cpu[c.task_index];
                r.read_slice = tbl_slice[c.task_index];
                r.last       = 1'b1;
                expected_results.push_back(r);
            end
            mtd_pkg::CMD_TICK:
            begin
                count = (task_limit > NTASK) ? NTASK : task_limit;
                ncpu  = (cpu_limit > NCPU) ? NCPU : cpu_limit;
                for (int i = 0; i < count; i++)
                    if (tbl_state[i] == mtd_pkg::ST_RUNNING && tbl_slice[i] >= quantum)
                    begin
                        tbl_state[i] = mtd_pkg::ST_READY;
                        tbl_cpu[i]   = mtd_pkg::CPU_NONE;
                        tbl_slice[i] = '0;
                    end
                for (int cp = 0; cp < ncpu; cp++)
                begin
                    prev  = cpu_task[cp];
                    cur   = -1;
                    drawn = 1'b0;
                    if (prev >= 0 && prev < count &&
                        (tbl_state[prev] == mtd_pkg::ST_READY ||
                         tbl_state[prev] == mtd_pkg::ST_RUNNING))
                        cur = prev;
                    for (int i = 0; i < count; i++)
                        if (tbl_state[i] == mtd_pkg::ST_RUNNING && tbl_cpu[i] == cp)
                            tbl_state[i] = mtd_pkg::ST_READY;
                    chosen      = best_ready(count, cur, drawn);
                    r           = '0;
                    r.cpu_index = cp[1:0];
                    r.lottery   = drawn;
                    if (chosen < 0)
                        cpu_task[cp] = -1;
                    else
                    begin
                        cpu_task[cp]      = chosen;
                        tbl_state[chosen] = mtd_pkg::ST_RUNNING;
                        tbl_cpu[chosen]   = cp[2:0];
                        if (prev != chosen)
                            tbl_slice[chosen] = '0;
                        r.chosen_task = chosen[4:0];
                        r.assigned    = 1'b1;
                        r.switched    = (prev != chosen);
                    end
                    r.last = (cp + 1 == ncpu);
                    expected_results.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    function automatic mtd_pkg::cmd_t table_write(int idx, logic [1:0] st, logic [15:0] rem,
                                                  logic [7:0] pri, logic [15:0] arr,
                                                  logic [15:0] dur, logic [15:0] sl,
                                                  logic [2:0] cp);
        mtd_pkg::cmd_t c;
        c.command        = mtd_pkg::CMD_WRITE;
        c.task_index     = idx[4:0];
        c.task_state     = st;
        c.remain_ticks   = rem;
        c.priority_level = pri;
        c.arrive_tick    = arr;
        c.total_duration = dur;
        c.slice_ticks    = sl;
        c.running_cpu    = cp;
        return c;
    endfunction

    function automatic logic [15:0] tie_prone16();
        return ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    endfunction

    function automatic mtd_pkg::cmd_t random_cmd();
        mtd_pkg::cmd_t c;
        int   sel;
        sel = $urandom_range(0, 99);
        c   = table_write($urandom_range(0, 31),
                          ($urandom_range(0, 9) < 8) ? 2'($urandom_range(1, 2))
                                                     : 2'($urandom_range(0, 3)),
                          tie_prone16(),
                          ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3))
                                                     : 8'($urandom),
                          tie_prone16(), tie_prone16(),
                          ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 12))
                                                     : 16'($urandom),
                          ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                                     : 3'($urandom_range(0, 7)));
        if (sel >= 95)
            c.command = CMD_NOP;
        else if (sel >= 80)
            c.command = mtd_pkg::CMD_READ;
        else if (sel >= 40)
            c.command = mtd_pkg::CMD_TICK;
        return c;
    endfunction

    task automatic reg_write(input logic [1:0] regsel, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regsel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (regsel)
            mtd_pkg::REG_MODE:    mode_prio  = value[0];
            mtd_pkg::REG_TASKS:   task_limit = value[5:0];
            mtd_pkg::REG_CPUS:    cpu_limit  = value[2:0];
            mtd_pkg::REG_QUANTUM: quantum    = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic m, input int t, input int cp, input int q);
        reg_write(mtd_pkg::REG_MODE, 32'(m));
        reg_write(mtd_pkg::REG_TASKS, 32'(t));
        reg_write(mtd_pkg::REG_CPUS, 32'(cp));
        reg_write(mtd_pkg::REG_QUANTUM, 32'(q));
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || start || busy || expected_results.size() != 0);
        repeat (8) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic random_phase(input int n, input bit gaps);
        idle_en = gaps;
        repeat (n) pending_cmds.push_back(random_cmd());
        drain();
    endtask

    // driver
    always @(posedge clk)
    begin
        bit nxt;
        if (rst_n)
        begin
            nxt = start;
            if (start && !busy)
            begin
                predict_dispatch(cmd);
                if (cmd.command == mtd_pkg::CMD_TICK) ticks_sent++;
                if (cmd.command == mtd_pkg::CMD_READ) reads_sent++;
                nxt = 1'b0;
            end
            if (!nxt)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_cmds.size() != 0)
                begin
                    nxt = 1'b1;
                    cmd <= pending_cmds.pop_front();
                    if (idle_en)
                        gap_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                              : $urandom_range(10, 40);
                end
            end
            start <= nxt;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        mtd_pkg::result_t exp_r;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else if (rst_n && result_strobe)
        begin
            results_seen++;
            if (result.lottery) coin_results++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %p", result);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (result !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, result);
                end
            end
        end
    end

    initial
    begin
        mtd_pkg::cmd_t c;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mode_prio = 1'b0; task_limit = '0; cpu_limit = 3'd1; quantum = 16'd4;
        for (int i = 0; i < NCPU; i++) cpu_task[i] = -1;
        for (int i = 0; i < NTASK; i++)
        begin
            tbl_state[i] = '0; tbl_remain[i] = '0; tbl_prio[i] = '0; tbl_arrival[i] = '0;
            tbl_duration[i] = '0; tbl_slice[i] = '0; tbl_cpu[i] = '0;
        end
        coin_reg = mtd_pkg::LFSR_SEED;
        gap_left = 0; idle_en = 1'b0; cycles = 0; mismatches = 0;
        ticks_sent = 0; reads_sent = 0; coin_results = 0; results_seen = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // every entry is written before anything reads the table
        pending_cmds.push_back(table_write(0, mtd_pkg::ST_READY, 16'hFFFF, 8'hFF, 16'hFFFF,
                                           16'hFFFF, 16'hFFFF, 3'd7));
        pending_cmds.push_back(table_write(1, 2'd3, 16'h0, 8'h0, 16'h0, 16'h0, 16'h0, 3'd0));
        for (int i = 2; i < NTASK; i++)
            pending_cmds.push_back(table_write(i, (i % 3 == 0) ? mtd_pkg::ST_RUNNING
                                                               : mtd_pkg::ST_READY,
                                               16'd5, 8'd9, 16'd2, 16'd7,
                                               16'(i % 6), 3'(i % 5)));
        drain();
        set_regs(1'b0, 32, 4, 4);
        idle_en = 1'b1;
        c = table_write(0, 2'd0, '0, '0, '0, '0, '0, '0);
        c.command = mtd_pkg::CMD_TICK;
        pending_cmds.push_back(c);
        c.command = CMD_NOP;
        pending_cmds.push_back(c);
        c.command = mtd_pkg::CMD_READ;
        pending_cmds.push_back(c);
        c.task_index = 5'd31;
        pending_cmds.push_back(c);
        c.command = mtd_pkg::CMD_TICK;
        pending_cmds.push_back(c);
        drain();
        set_regs(1'b1, 32, 4, 0);
        pending_cmds.push_back(c);
        drain();

        random_phase(45, 1'b1);
        set_regs(1'b0, 8, 2, 65535);
        random_phase(45, 1'b0);
        set_regs(1'b1, 1, 1, 1);
        random_phase(40, 1'b1);
        set_regs(1'b0, 63, 7, 3);
        random_phase(45, 1'b1);
        set_regs(1'b1, 0, 0, 2);
        random_phase(30, 1'b1);
        set_regs(1'b0, 32, 3, 10);
        random_phase(40, 1'b0);
        set_regs(1'b1, 20, 4, 5);
        random_phase(40, 1'b1);
        set_regs(1'b0, 32, 4, 1);
        random_phase(40, 1'b1);
        repeat (400) @(posedge clk);

        $display("covered %0d ticks and %0d reads, %0d results, %0d decided by coin",
                 ticks_sent, reads_sent, results_seen, coin_results);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches, %0d results outstanding",
                     mismatches, expected_results.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> multicore_task_dispatcher.f
rtl/core/mtd_pkg.sv
rtl/core/mtd_ram.sv
rtl/core/mtd_datapath.sv
rtl/core/mtd_ctrl.sv
rtl/core/multicore_task_dispatcher.sv
tb/multicore_task_dispatcher_tb.sv
